// ===== design/nst_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Named semaphore table package
// Table sizes, operation and status codes, and controller states.
// ---------------------------------------------------------------------------
package nst_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int NAME_BYTES = 19;
    localparam int NAME_BITS  = 8 * NAME_BYTES;
    localparam logic [7:0] NAME_MAX_LEN = 8'(NAME_BYTES);

    localparam int IN_BITS  = 184;
    localparam int OUT_BITS = 32;

    typedef enum logic [1:0] {
        OP_OPEN   = 2'd0,
        OP_WAIT   = 2'd1,
        OP_POST   = 2'd2,
        OP_UNLINK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_BLOCK    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CNT_RD,
        S_CNT_OP,
        S_RESP
    } state_t;

endpackage

// ===== design/named_semaphore_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Named semaphore table
// Counting semaphores keyed by names of up to 19 bytes: open, wait, post and
// unlink, one result per request.
// ---------------------------------------------------------------------------
// Channel  Dir  Fields (lowest bit first)
// s_axis   in   op, name_bytes_low, name_bytes_mid, name_bytes_top,
//               name_length, start_count, handle
// m_axis   out  status, handle_out, count_out
//
// Open and unlink scan the name RAM, one entry a cycle with the compare in the
// cycle after the read. Wait and post read, modify and write the count RAM.
// Used marks sit in flip-flops and clear at reset; no clearing pass.
// A request is taken only when idle; a result waiting in the output register
// stalls only the finish of the next request.
// ---------------------------------------------------------------------------
module named_semaphore_table
    import nst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // op[1:0], name_bytes_low[65:2], name_bytes_mid[129:66],
    // name_bytes_top[153:130], name_length[161:154], start_count[177:162],
    // handle[183:178]
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[2:0], handle_out[8:3], count_out[24:9], zero[31:25]
    output logic [OUT_BITS-1:0] m_tdata
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(ENTRIES - 1);

    state_t                  state_reg, state_next;
    logic [ENTRIES-1:0]      used_reg, used_next;
    op_t                     op_reg, op_next;
    logic [NAME_BITS-1:0]    key_reg, key_next;
    logic [COUNT_BITS-1:0]   start_reg, start_next;
    logic [IDX_BITS-1:0]     target_reg, target_next;
    logic [IDX_BITS-1:0]     scan_idx_reg, scan_idx_next;
    logic [IDX_BITS-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    status_t                 res_status_reg, res_status_next;
    logic [5:0]              res_handle_reg, res_handle_next;
    logic [15:0]             res_count_reg, res_count_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_BITS-1:0]     m_tdata_reg, m_tdata_next;

    logic [1:0]              in_op;
    logic [NAME_BITS-1:0]    in_name;
    logic [7:0]              in_len;
    logic [15:0]             in_start;
    logic [5:0]              in_handle;
    logic [NAME_BITS-1:0]    name_mask;
    logic [COUNT_BITS-1:0]   start_sat;
    logic                    free_found;
    logic [IDX_BITS-1:0]     free_idx;
    logic                    hit;

    logic                    name_we, name_re;
    logic [IDX_BITS-1:0]     name_waddr;
    logic [NAME_BITS-1:0]    name_rdata;
    logic                    cnt_we, cnt_re;
    logic [IDX_BITS-1:0]     cnt_waddr;
    logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;

    assign in_op     = s_tdata[1:0];
    assign in_name   = s_tdata[153:2];
    assign in_len    = s_tdata[161:154];
    assign in_start  = s_tdata[177:162];
    assign in_handle = s_tdata[183:178];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            name_mask[8*b +: 8] = (in_len > 8'(b)) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        if ({16'd0, in_start} > 32'(COUNT_MAX))
        begin
            start_sat = COUNT_MAX;
        end
        else
        begin
            start_sat = COUNT_BITS'(in_start);
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
    end

    assign hit = cmp_valid_reg && used_reg[cmp_idx_reg] && (name_rdata == key_reg);

    assign name_re    = (state_reg == S_SCAN);
    assign name_waddr = free_idx;
    assign cnt_re     = (state_reg == S_CNT_RD);

    nst_ram #(
        .WIDTH (NAME_BITS),
        .DEPTH (ENTRIES)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (key_reg),
        .re    (name_re),
        .raddr (scan_idx_reg),
        .rdata (name_rdata)
    );

    nst_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (target_reg),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        start_reg      <= start_next;
        target_reg     <= target_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_valid_reg  <= cmp_valid_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_count_reg  <= res_count_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        start_next      = start_reg;
        target_next     = target_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        name_we         = 1'b0;
        cnt_we          = 1'b0;
        cnt_waddr       = target_reg;
        cnt_wdata       = cnt_rdata;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = op_t'(in_op);
                    start_next      = start_sat;
                    res_handle_next = '0;
                    res_count_next  = '0;
                    if ((op_t'(in_op) == OP_OPEN) || (op_t'(in_op) == OP_UNLINK))
                    begin
                        if (in_len > NAME_MAX_LEN)
                        begin
                            res_status_next = ST_TOO_LONG;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            key_next       = in_name & name_mask;
                            scan_idx_next  = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    else if ((7'(in_handle) >= 7'(ENTRIES)) ||
                             !used_reg[IDX_BITS'(in_handle)])
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        target_next = IDX_BITS'(in_handle);
                        state_next  = S_CNT_RD;
                    end
                end
            end

            S_SCAN:
            begin
                scan_idx_next  = scan_idx_reg + 1'b1;
                cmp_idx_next   = scan_idx_reg;
                cmp_valid_next = 1'b1;
                if (hit)
                begin
                    target_next = cmp_idx_reg;
                    state_next  = S_CNT_RD;
                end
                else if (cmp_valid_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    state_next = S_RESP;
                    if (op_reg == OP_UNLINK)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else if (free_found)
                    begin
                        name_we              = 1'b1;
                        cnt_we               = 1'b1;
                        cnt_waddr            = free_idx;
                        cnt_wdata            = start_reg;
                        used_next[free_idx]  = 1'b1;
                        res_status_next      = ST_OK;
                        res_handle_next      = 6'(free_idx);
                        res_count_next       = 16'(start_reg);
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
            end

            S_CNT_RD:
            begin
                state_next = S_CNT_OP;
            end

            S_CNT_OP:
            begin
                state_next      = S_RESP;
                res_status_next = ST_OK;
                res_handle_next = 6'(target_reg);
                res_count_next  = 16'(cnt_rdata);
                case (op_reg)
                    OP_WAIT:
                    begin
                        if (cnt_rdata == '0)
                        begin
                            res_status_next = ST_BLOCK;
                            res_count_next  = '0;
                        end
                        else
                        begin
                            cnt_we         = 1'b1;
                            cnt_wdata      = cnt_rdata - 1'b1;
                            res_count_next = 16'(cnt_wdata);
                        end
                    end
                    OP_POST:
                    begin
                        if (cnt_rdata != COUNT_MAX)
                        begin
                            cnt_we         = 1'b1;
                            cnt_wdata      = cnt_rdata + 1'b1;
                            res_count_next = 16'(cnt_wdata);
                        end
                    end
                    OP_UNLINK:
                    begin
                        used_next[target_reg] = 1'b0;
                    end
                    default:
                    begin
                        // open of an existing name: report its count
                    end
                endcase
            end

            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, res_count_reg, res_handle_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_entry_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CNT_OP) |-> used_reg[target_reg])
        else $error("count accessed for an unused entry");

    a_claim_free_entry: assert property (@(posedge clk) disable iff (!rst_n)
        name_we |-> (!used_reg[name_waddr] && (op_reg == OP_OPEN)))
        else $error("name written into a used entry");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && (res_status_reg != ST_OK)) |-> (res_count_reg == '0))
        else $error("count reported with an error status");

    a_claim_sets_used: assert property (@(posedge clk) disable iff (!rst_n)
        name_we |=> used_reg[$past(name_waddr)])
        else $error("claimed entry not marked used");

endmodule

// ===== design/nst_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Named semaphore table testbench
// Drives open, wait, post and unlink requests into the stream input while the
// result side stalls in its own pattern. Every accepted request is run through
// a local model of the table, and each result is checked field by field
// against the oldest prediction. A directed opening covers the edge cases,
// then random traffic works a pool of names that is larger than the table.
// ---------------------------------------------------------------------------
import nst_pkg::*;

typedef struct packed {
    logic [5:0]  handle;
    logic [15:0] start_count;
    logic [7:0]  name_length;
    logic [23:0] name_top;
    logic [63:0] name_mid;
    logic [63:0] name_low;
    op_t         op;
} sem_request_t;

typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] count_out;
    logic [5:0]  handle_out;
    status_t     status;
} sem_reply_t;

class semaphore_ledger;
    bit                    slot_used [ENTRIES];
    logic [63:0]           slot_low [ENTRIES];
    logic [63:0]           slot_mid [ENTRIES];
    logic [23:0]           slot_top [ENTRIES];
    logic [COUNT_BITS-1:0] slot_count [ENTRIES];
    sem_reply_t            pending_replies[$];
    int                    mismatches;
    int                    status_hits [5];

    function logic [63:0] keep_bytes(int bytes, int width);
        if (bytes >= width)
            return (width >= 8) ? '1 : (64'd1 << (8 * width)) - 64'd1;
        return (64'd1 << (8 * bytes)) - 64'd1;
    endfunction

    function void note_request(sem_request_t req);
        sem_reply_t  rep;
        logic [63:0] key_low;
        logic [63:0] key_mid;
        logic [23:0] key_top;
        int          len;
        int          hit;
        int          free_slot;
        rep = '0;
        rep.status = ST_OK;
        len = req.name_length;
        if (req.op == OP_OPEN || req.op == OP_UNLINK)
        begin
            if (req.name_length > NAME_MAX_LEN)
            begin
                rep.status = ST_TOO_LONG;
            end
            else
            begin
                key_low = req.name_low & keep_bytes(len, 8);
                key_mid = req.name_mid & keep_bytes(len > 8 ? len - 8 : 0, 8);
                key_top = req.name_top & 24'(keep_bytes(len > 16 ? len - 16 : 0, 3));
                hit = -1;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (slot_used[i] && slot_low[i] == key_low && slot_mid[i] == key_mid
                        && slot_top[i] == key_top)
                        hit = i;
                if (req.op == OP_OPEN)
                begin
                    if (hit < 0)
                    begin
                        free_slot = -1;
                        for (int i = ENTRIES - 1; i >= 0; i--)
                            if (!slot_used[i])
                                free_slot = i;
                        if (free_slot >= 0)
                        begin
                            slot_used[free_slot] = 1'b1;
                            slot_low[free_slot]  = key_low;
                            slot_mid[free_slot]  = key_mid;
                            slot_top[free_slot]  = key_top;
                            if (32'(req.start_count) > 32'({COUNT_BITS{1'b1}}))
                                slot_count[free_slot] = '1;
                            else
                                slot_count[free_slot] = COUNT_BITS'(req.start_count);
                            hit = free_slot;
                        end
                    end
                    if (hit < 0)
                    begin
                        rep.status = ST_FULL;
                    end
                    else
                    begin
                        rep.handle_out = 6'(hit);
                        rep.count_out  = 16'(slot_count[hit]);
                    end
                end
                else if (hit < 0)
                begin
                    rep.status = ST_INVALID;
                end
                else
                begin
                    slot_used[hit] = 1'b0;
                    rep.handle_out = 6'(hit);
                    rep.count_out  = 16'(slot_count[hit]);
                end
            end
        end
        else if (req.handle >= ENTRIES || !slot_used[req.handle])
        begin
            rep.status = ST_INVALID;
        end
        else
        begin
            rep.handle_out = req.handle;
            if (req.op == OP_WAIT)
            begin
                if (slot_count[req.handle] == '0)
                    rep.status = ST_BLOCK;
                else
                    slot_count[req.handle] = slot_count[req.handle] - 1'b1;
            end
            else if (slot_count[req.handle] != '1)
            begin
                slot_count[req.handle] = slot_count[req.handle] + 1'b1;
            end
            if (rep.status == ST_OK)
                rep.count_out = 16'(slot_count[req.handle]);
        end
        pending_replies.push_back(rep);
    endfunction

    function void check_reply(sem_reply_t got);
        sem_reply_t want;
        if (pending_replies.size() == 0)
        begin
            $error("result with no request outstanding: status %0d handle %0d count %0d",
                   got.status, got.handle_out, got.count_out);
            mismatches++;
            return;
        end
        want = pending_replies.pop_front();
        status_hits[want.status]++;
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.handle_out !== want.handle_out)
        begin
            $error("handle_out: expected %0d, got %0d", want.handle_out, got.handle_out);
            mismatches++;
        end
        if (got.count_out !== want.count_out)
        begin
            $error("count_out: expected %0d, got %0d", want.count_out, got.count_out);
            mismatches++;
        end
    endfunction
endclass

module tb;

    localparam int POOL_SIZE   = 24;
    localparam int RANDOM_REQS = 1050;
    localparam int HOLD_CYCLES = 300;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    semaphore_ledger ledger = new();

    logic [63:0] pool_low [POOL_SIZE];
    logic [63:0] pool_mid [POOL_SIZE];
    logic [23:0] pool_top [POOL_SIZE];
    logic [7:0]  pool_len [POOL_SIZE];
    int          requests_sent;
    int          burst_left;
    bit          hold_asked;
    bit          hold_done;
    int          rx_tick;

    named_semaphore_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("named_semaphore_table: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                ledger.check_reply(sem_reply_t'(m_tdata));
            if (s_tvalid && s_tready)
                ledger.note_request(sem_request_t'(s_tdata));
        end
    end

    initial
    begin
        m_tready  = 1'b0;
        rx_tick   = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                rx_tick++;
                case (rx_tick[9:8])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_tready <= (rx_tick[3:2] == 2'd0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    function automatic sem_request_t make_request(op_t op, logic [63:0] low,
                                                  logic [63:0] mid, logic [23:0] top,
                                                  logic [7:0] len, logic [15:0] start,
                                                  logic [5:0] handle);
        sem_request_t req;
        req.op          = op;
        req.name_low    = low;
        req.name_mid    = mid;
        req.name_top    = top;
        req.name_length = len;
        req.start_count = start;
        req.handle      = handle;
        return req;
    endfunction

    task automatic send_request(input sem_request_t req);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge clk); while (!s_tready);
        requests_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            // run the first 60 of every 300 transactions back to back
            gap = (requests_sent % 300 < 60 || $urandom_range(0, 3) == 0)
                  ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic logic [15:0] pick_start();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 16'($urandom_range(0, 3));
        if (sel < 9)
            return 16'($urandom_range(0, 65535));
        return 16'hFFFF;
    endfunction

    task automatic open_pool(int k, logic [15:0] start);
        send_request(make_request(OP_OPEN, pool_low[k], pool_mid[k], pool_top[k],
                                  pool_len[k], start, 6'($urandom)));
    endtask

    task automatic touch_handle(op_t op, logic [5:0] handle);
        send_request(make_request(op, {$urandom, $urandom}, {$urandom, $urandom},
                                  24'($urandom), 8'($urandom), 16'($urandom), handle));
    endtask

    initial
    begin
        sem_request_t req;
        int           pick;
        int           k;
        logic [63:0]  fresh;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        requests_sent = 0;
        burst_left    = 0;
        hold_asked    = 1'b0;

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_low[i] = {$urandom, $urandom};
            pool_mid[i] = {$urandom, $urandom};
            pool_top[i] = 24'($urandom);
            pool_len[i] = 8'($urandom_range(1, 19));
        end
        pool_len[0] = 8'd0;
        pool_low[1] = '1;
        pool_mid[1] = '1;
        pool_top[1] = '1;
        pool_len[1] = 8'd19;
        pool_low[2] = {pool_low[2][63:8], 8'h41};
        pool_len[2] = 8'd1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty name at full count, then saturate it
        open_pool(0, 16'hFFFF);
        touch_handle(OP_POST, 6'd0);
        // one-byte name: block at zero, count up and down
        open_pool(2, 16'd0);
        touch_handle(OP_WAIT, 6'd1);
        touch_handle(OP_POST, 6'd1);
        touch_handle(OP_WAIT, 6'd1);
        // same name padded with zero bytes inside its length
        send_request(make_request(OP_OPEN, pool_low[2] & 64'hFF, {$urandom, $urandom},
                                  24'($urandom), 8'd3, 16'd9, 6'd0));
        open_pool(1, 16'h8000);
        send_request(make_request(OP_OPEN, '1, '1, '1, 8'd20, 16'd1, 6'd0));
        send_request(make_request(OP_OPEN, '1, '1, '1, 8'd255, 16'd1, 6'd0));
        send_request(make_request(OP_UNLINK, pool_low[1], pool_mid[1], pool_top[1],
                                  8'd20, 16'd0, 6'd0));
        touch_handle(OP_WAIT, 6'd63);
        touch_handle(OP_POST, 6'(ENTRIES));
        touch_handle(OP_POST, 6'(ENTRIES - 1));
        send_request(make_request(OP_UNLINK, pool_low[3], pool_mid[3], pool_top[3],
                                  pool_len[3], 16'd0, 6'd0));
        send_request(make_request(OP_UNLINK, pool_low[2], pool_mid[2], pool_top[2],
                                  pool_len[2], 16'd0, 6'd0));
        // fill the table, then one open too many
        for (int i = 3; i < 3 + ENTRIES - 2; i++)
            open_pool(i, pick_start());
        open_pool(3 + ENTRIES - 2, 16'd7);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == RANDOM_REQS / 2)
                hold_asked = 1'b1;
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL_SIZE - 1);
            req  = make_request(OP_OPEN, pool_low[k], pool_mid[k], pool_top[k], pool_len[k],
                                pick_start(),
                                6'($urandom_range(0, 9) < 8 ? $urandom_range(0, ENTRIES - 1)
                                                            : $urandom_range(0, 63)));
            if ($urandom_range(0, 3) == 0)
            begin
                fresh = {$urandom, $urandom};
                req.name_low ^= fresh & ~ledger.keep_bytes(pool_len[k], 8);
            end
            if (pick < 30)
                req.op = OP_OPEN;
            else if (pick < 55)
                req.op = OP_WAIT;
            else if (pick < 75)
                req.op = OP_POST;
            else if (pick < 88)
                req.op = OP_UNLINK;
            else
                req = sem_request_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom,
                                               $urandom, $urandom}));
            send_request(req);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (ledger.pending_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d transactions: %0d ok, %0d invalid, %0d table full,",
                 requests_sent, ledger.status_hits[ST_OK], ledger.status_hits[ST_INVALID],
                 ledger.status_hits[ST_FULL]);
        $display("%0d name too long, %0d would block, one long result-side hold",
                 ledger.status_hits[ST_TOO_LONG], ledger.status_hits[ST_BLOCK]);
        if (ledger.mismatches == 0)
            $display("named_semaphore_table: match");
        else
            $display("named_semaphore_table: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/nst_pkg.sv
design/nst_ram.sv
design/named_semaphore_table.sv
bench/tb.sv
